// File: hdl/pavm_pkg.sv
package pavm_pkg;

   localparam int MAX_VOICES_DEF       = 16;
   localparam int SAMPLE_RATE_DEF      = 48000;
   localparam int SINE_DEPTH_DEF       = 256;
   localparam int FRAME_BITS_DEF       = 24;

   localparam int CFG_IDX_BITS = 3;
   localparam logic [CFG_IDX_BITS-1:0] REG_WAVEFORM = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK   = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] REG_DECAY    = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN  = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE  = 3'd4;
   localparam logic [CFG_IDX_BITS-1:0] REG_VOLUME   = 3'd5;

   localparam logic [1:0] ACT_TICK = 2'd0;
   localparam logic [1:0] ACT_ON   = 2'd1;
   localparam logic [1:0] ACT_OFF  = 2'd2;

   localparam logic [1:0] WAVE_SINE = 2'd0;
   localparam logic [1:0] WAVE_TRI  = 2'd1;
   localparam logic [1:0] WAVE_SQR  = 2'd2;

   // semitone ratios in q16
   function automatic logic [16:0] semitone_q16(input logic [3:0] n);
      logic [16:0] r;
      begin
         unique case (n)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd69433;
            4'd2:  r = 17'd73562;
            4'd3:  r = 17'd77936;
            4'd4:  r = 17'd82570;
            4'd5:  r = 17'd87480;
            4'd6:  r = 17'd92682;
            4'd7:  r = 17'd98193;
            4'd8:  r = 17'd104032;
            4'd9:  r = 17'd110218;
            4'd10: r = 17'd116772;
            default: r = 17'd123715;
         endcase
         semitone_q16 = r;
      end
   endfunction

   // phase increment per key, evaluated into a constant table at elaboration
   function automatic logic [31:0] phase_step(input int key, input int rate);
      int unsigned m;
      logic [127:0] num;
      begin
         m = key + 3;
         num = (128'(440) * 128'(semitone_q16(4'(m % 12)))) << (m / 12 + 10);
         phase_step = 32'((num + 128'(rate / 2)) / 128'(rate));
      end
   endfunction

endpackage

// File: hdl/pavm_ram.sv
module pavm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hdl/polyphonic_adsr_voice_mixer.sv
// channel | direction | tdata / data (low bit first)           | tuser / other
// req     | in        | key[6:0], start_phase[22:7], pad to 24   | action[1:0]
// rsp     | out       | sample[15:0], active_voices[20:16], pad  | -
// csr     | in        | csr_data[23:0]                           | csr_index[2:0]
//
// note on is accepted directly in idle; note off scans the voices one by one for its key.
// a tick visits each voice: a sine wave also runs the polynomial, and the attack or decay
// ramp and the release fade each run a serial divide; the last voice is moved into the slot
// of a removed voice. products go through one shared 32x32 multiplier.
// reset is synchronous; it empties the voice table and loads register defaults.
// a pending result holds in rsp until taken; req stays low until then.
module polyphonic_adsr_voice_mixer #(
   parameter int MAX_VOICES       = pavm_pkg::MAX_VOICES_DEF,
   parameter int SAMPLE_RATE_HZ   = pavm_pkg::SAMPLE_RATE_DEF,
   parameter int SINE_TABLE_DEPTH = pavm_pkg::SINE_DEPTH_DEF,
   parameter int FRAME_COUNT_BITS = pavm_pkg::FRAME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // key[6:0], start_phase[22:7]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // sample[15:0], active_voices[20:16]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [pavm_pkg::CFG_IDX_BITS-1:0] csr_index,
   input  logic [23:0] csr_data
);
   localparam int VB  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CB  = $clog2(MAX_VOICES + 1);
   localparam int FB  = FRAME_COUNT_BITS;
   localparam int SB  = $clog2(SINE_TABLE_DEPTH);
   localparam int VW  = 7 + 1 + 32 + FB + FB;
   localparam logic [FB-1:0] CMAX = {FB{1'b1}};
   localparam logic [63:0] Q30 = 64'd1073741824;

   // voice record: key, held, phase, fs, fr
   typedef struct packed {
      logic [6:0]    key;
      logic          held;
      logic [31:0]   phase;
      logic [FB-1:0] fs;
      logic [FB-1:0] fr;
   } voice_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_OFF_RD, ST_OFF_CHK, ST_TICK_RD, ST_TICK_WAIT, ST_WAVE,
      ST_SIN_X2, ST_SIN_P, ST_SIN_R, ST_ENV, ST_ENV_DIV, ST_REL, ST_REL_DIV,
      ST_MIX1, ST_MIX2, ST_MIX3, ST_MIX4, ST_UPD, ST_LAST_RD, ST_LAST_WAIT, ST_MOVE,
      ST_NEXT, ST_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [1:0]  waveform_ff;
   logic [23:0] attack_ff, decay_ff, release_ff;
   logic [15:0] sustain_ff, volume_ff;

   logic [CB-1:0] count_ff;
   logic [VB-1:0] idx_ff;
   logic [2:0]    step_ff;
   logic [6:0]    key_ff;
   voice_type     cur_ff;
   logic [15:0]   mix_ff;
   logic          wneg_ff;
   logic [16:0]   wmag_ff, env_ff;
   logic [63:0]   x_ff, x2_ff, p_ff, acc_ff;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // shared restoring divider, 41-bit numerator, 25-bit divisor
   logic [40:0] dq_ff;
   logic [25:0] drem_ff;
   logic [24:0] dden_ff;
   logic [5:0]  dcnt_ff;
   logic [25:0] dtrial;
   assign dtrial = {drem_ff[24:0], dq_ff[40]} - {1'b0, dden_ff};

   // ram
   logic          ram_we;
   logic [VB-1:0] ram_wa, ram_ra;
   voice_type     ram_wd, ram_rd;
   pavm_ram #(.WIDTH(VW), .DEPTH(MAX_VOICES)) u_ram (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   // sine polynomial coefficients, applied highest first
   function automatic logic [31:0] sin_coef(input logic [2:0] i);
      unique case (i)
         3'd0: sin_coef = 32'd5026995;
         3'd1: sin_coef = 32'd85569306;
         3'd2: sin_coef = 32'd693598668;
         default: sin_coef = 32'd1686629713;
      endcase
   endfunction

   logic [31:0] inc;
   always_comb begin
      inc = '0;
      for (int k = 0; k < 128; k++)
         if (cur_ff.key == 7'(k)) inc = pavm_pkg::phase_step(k, SAMPLE_RATE_HZ);
   end

   logic [16:0] sus;
   assign sus = (sustain_ff > 16'd32768) ? 17'd32768 : {1'b0, sustain_ff};
   logic [FB-1:0] dfr;
   assign dfr = (cur_ff.fs >= cur_ff.fr) ? cur_ff.fs - cur_ff.fr : '0;
   logic [31:0] tq;
   assign tq = {cur_ff.phase[31 -: SB], {(32-SB){1'b0}}};

   logic signed [17:0] addend;
   logic signed [18:0] sum;
   assign addend = wneg_ff ? -$signed({1'b0, acc_ff[16:0]}) : $signed({1'b0, acc_ff[16:0]});
   assign sum = 19'(addend) + 19'($signed(mix_ff));

   voice_type upd;
   always_comb begin
      upd = cur_ff;
      upd.phase = cur_ff.phase + inc;
      if (!cur_ff.held && cur_ff.fr < CMAX) upd.fr = cur_ff.fr + 1'b1;
      if (cur_ff.fs < CMAX) upd.fs = cur_ff.fs + 1'b1;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SIN_X2: begin mul_a = x_ff[31:0]; mul_b = x_ff[31:0]; end
         ST_SIN_P:  begin mul_a = x2_ff[31:0]; mul_b = p_ff[31:0]; end
         ST_SIN_R:  begin mul_a = x_ff[31:0]; mul_b = p_ff[31:0]; end
         ST_MIX1:   begin mul_a = 32'(wmag_ff); mul_b = 32'(env_ff); end
         ST_MIX2:   begin mul_a = acc_ff[31:0]; mul_b = 32'd32767; end
         ST_MIX3:   begin mul_a = acc_ff[31:0]; mul_b = 32'(volume_ff); end
         ST_MIX4:   begin mul_a = acc_ff[63:32]; mul_b = 32'(volume_ff); end
         default:   begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE) && !rsp_tvalid;
   assign csr_ready  = 1'b1;

   always_comb begin
      ram_we = 1'b0;
      ram_wa = idx_ff;
      ram_wd = upd;
      ram_ra = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ram_wa = VB'(count_ff);
            ram_wd.key = req_tdata[6:0];
            ram_wd.held = 1'b1;
            ram_wd.phase = {req_tdata[22:7], 16'd0};
            ram_wd.fs = '0;
            ram_wd.fr = '0;
            ram_we = req_tvalid && req_tready && req_tuser == pavm_pkg::ACT_ON
                     && count_ff < CB'(MAX_VOICES);
         end
         ST_OFF_CHK: begin
            ram_wd = ram_rd;
            ram_wd.held = 1'b0;
            ram_wd.fr = '0;
            ram_we = ram_rd.held && ram_rd.key == key_ff;
         end
         ST_UPD: ram_we = !(32'(upd.fr) > 32'(release_ff)) ||
                          (idx_ff == VB'(count_ff - 1'b1));
         ST_LAST_RD: ram_ra = VB'(count_ff);
         // keep the last voice addressed so its record is still there on the move
         ST_LAST_WAIT: ram_ra = VB'(count_ff);
         ST_MOVE: begin ram_we = 1'b1; ram_wd = ram_rd; end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         waveform_ff <= '0;
         attack_ff   <= '0;
         decay_ff    <= '0;
         sustain_ff  <= 16'd32768;
         release_ff  <= '0;
         volume_ff   <= 16'd16384;
         count_ff    <= '0;
         dcnt_ff     <= '0;
         rsp_tvalid  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               pavm_pkg::REG_WAVEFORM: waveform_ff <= csr_data[1:0];
               pavm_pkg::REG_ATTACK:   attack_ff <= csr_data;
               pavm_pkg::REG_DECAY:    decay_ff <= csr_data;
               pavm_pkg::REG_SUSTAIN:  sustain_ff <= csr_data[15:0];
               pavm_pkg::REG_RELEASE:  release_ff <= csr_data;
               pavm_pkg::REG_VOLUME:   volume_ff <= csr_data[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) rsp_tvalid <= 1'b0;
         // divider runs whenever armed
         if (dcnt_ff != '0) begin
            if (!dtrial[25]) begin
               drem_ff <= dtrial;
               dq_ff <= {dq_ff[39:0], 1'b1};
            end else begin
               drem_ff <= {drem_ff[24:0], dq_ff[40]};
               dq_ff <= {dq_ff[39:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: if (req_tvalid && req_tready) begin
               key_ff <= req_tdata[6:0];
               mix_ff <= '0;
               if (req_tuser == pavm_pkg::ACT_ON) begin
                  if (count_ff < CB'(MAX_VOICES)) count_ff <= count_ff + 1'b1;
               end else if (req_tuser == pavm_pkg::ACT_OFF) begin
                  idx_ff <= '0;
                  if (count_ff != '0) state_ff <= ST_OFF_RD;
               end else if (req_tuser == pavm_pkg::ACT_TICK) begin
                  if (count_ff == '0) state_ff <= ST_OUT;
                  else begin
                     idx_ff <= VB'(count_ff - 1'b1);
                     state_ff <= ST_TICK_RD;
                  end
               end
            end
            ST_OFF_RD: state_ff <= ST_OFF_CHK;
            ST_OFF_CHK: begin
               if ((ram_rd.held && ram_rd.key == key_ff) ||
                   (CB'(idx_ff) + 1'b1 >= count_ff))
                  state_ff <= ST_IDLE;
               else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= ST_OFF_RD;
               end
            end
            ST_TICK_RD: state_ff <= ST_TICK_WAIT;
            ST_TICK_WAIT: begin
               cur_ff <= ram_rd;
               state_ff <= ST_WAVE;
            end
            ST_WAVE: begin
               unique case (waveform_ff)
                  pavm_pkg::WAVE_SINE: begin
                     wneg_ff <= tq[31];
                     x_ff <= tq[30] ? Q30 - 64'(tq[29:0]) : 64'(tq[29:0]);
                     state_ff <= ST_SIN_X2;
                  end
                  pavm_pkg::WAVE_TRI: begin
                     wneg_ff <= cur_ff.phase[31] ? (cur_ff.phase[30:15] > 16'd32768)
                                                 : (cur_ff.phase[30:15] < 16'd32768);
                     if (cur_ff.phase[31])
                        wmag_ff <= (cur_ff.phase[30:15] > 16'd32768)
                                   ? 17'({1'b0, cur_ff.phase[30:15]} - 17'd32768)
                                   : 17'd32768 - 17'(cur_ff.phase[30:15]);
                     else
                        wmag_ff <= (cur_ff.phase[30:15] < 16'd32768)
                                   ? 17'd32768 - 17'(cur_ff.phase[30:15])
                                   : 17'(cur_ff.phase[30:15]) - 17'd32768;
                     state_ff <= ST_ENV;
                  end
                  pavm_pkg::WAVE_SQR: begin
                     wneg_ff <= !cur_ff.phase[31];
                     wmag_ff <= 17'd32768;
                     state_ff <= ST_ENV;
                  end
                  default: begin
                     wneg_ff <= 1'b0;
                     wmag_ff <= '0;
                     state_ff <= ST_ENV;
                  end
               endcase
            end
            ST_SIN_X2: begin
               x2_ff <= mul_p >> 30;
               p_ff <= 64'd172272;
               step_ff <= '0;
               state_ff <= ST_SIN_P;
            end
            ST_SIN_P: begin
               p_ff <= 64'(sin_coef(step_ff)) - (mul_p >> 30);
               step_ff <= step_ff + 1'b1;
               if (step_ff == 3'd3) state_ff <= ST_SIN_R;
            end
            ST_SIN_R: begin
               wmag_ff <= (((mul_p >> 30) + 64'd16384) >> 15) > 64'd32768 ? 17'd32768
                          : 17'(((mul_p >> 30) + 64'd16384) >> 15);
               state_ff <= ST_ENV;
            end
            ST_ENV: begin
               if (attack_ff != '0 && 33'(dfr) < 33'(attack_ff)) begin
                  dq_ff <= 41'(dfr) << 15;
                  dden_ff <= {1'b0, attack_ff};
                  drem_ff <= '0; dcnt_ff <= 6'd41;
                  step_ff <= 3'd0;
                  state_ff <= ST_ENV_DIV;
               end else if (decay_ff != '0 &&
                            33'(dfr) < 33'(attack_ff) + 33'(decay_ff)) begin
                  dq_ff <= 41'(25'(dfr) - {1'b0, attack_ff}) * 41'(17'd32768 - sus);
                  dden_ff <= {1'b0, decay_ff};
                  drem_ff <= '0; dcnt_ff <= 6'd41;
                  step_ff <= 3'd1;
                  state_ff <= ST_ENV_DIV;
               end else begin
                  env_ff <= sus;
                  state_ff <= ST_REL;
               end
            end
            ST_ENV_DIV: if (dcnt_ff == '0) begin
               env_ff <= (step_ff == 3'd0) ? dq_ff[16:0] : 17'd32768 - dq_ff[16:0];
               state_ff <= ST_REL;
            end
            ST_REL: begin
               if (release_ff != '0 && cur_ff.fr != '0) begin
                  if (32'(cur_ff.fr) < 32'(release_ff)) begin
                     dq_ff <= 41'(env_ff) * 41'(24'(32'(release_ff) - 32'(cur_ff.fr)));
                     dden_ff <= {1'b0, release_ff};
                     drem_ff <= '0; dcnt_ff <= 6'd41;
                     state_ff <= ST_REL_DIV;
                  end else begin
                     env_ff <= '0;
                     state_ff <= ST_MIX1;
                  end
               end else state_ff <= ST_MIX1;
            end
            ST_REL_DIV: if (dcnt_ff == '0) begin
               env_ff <= dq_ff[16:0];
               state_ff <= ST_MIX1;
            end
            ST_MIX1: begin acc_ff <= mul_p; state_ff <= ST_MIX2; end
            ST_MIX2: begin acc_ff <= mul_p; state_ff <= ST_MIX3; end
            // product by volume in two 32-bit halves, low half first
            ST_MIX3: begin p_ff <= mul_p; state_ff <= ST_MIX4; end
            ST_MIX4: begin
               acc_ff <= ((mul_p << 32) + p_ff) >> 46;
               state_ff <= ST_UPD;
            end
            ST_UPD: begin
               if (sum > 19'sd32767) mix_ff <= 16'sh7fff;
               else if (sum < -19'sd32768) mix_ff <= 16'sh8000;
               else mix_ff <= sum[15:0];
               if (32'(upd.fr) > 32'(release_ff)) begin
                  count_ff <= count_ff - 1'b1;
                  if (idx_ff != VB'(count_ff - 1'b1)) state_ff <= ST_LAST_RD;
                  else state_ff <= ST_NEXT;
               end else state_ff <= ST_NEXT;
            end
            ST_LAST_RD: state_ff <= ST_LAST_WAIT;
            ST_LAST_WAIT: state_ff <= ST_MOVE;
            ST_MOVE: state_ff <= ST_NEXT;
            ST_NEXT: begin
               if (idx_ff == '0) state_ff <= ST_OUT;
               else begin
                  idx_ff <= idx_ff - 1'b1;
                  state_ff <= ST_TICK_RD;
               end
            end
            ST_OUT: if (!rsp_tvalid) begin
               rsp_tvalid <= 1'b1;
               rsp_tdata <= {3'd0, 5'(count_ff), mix_ff};
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(MAX_VOICES)) else $error("voice count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready) else $error("ready while busy");
   a_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_OUT) else $error("stray result");
endmodule
